// ===== hdl/sbm_pkg.sv =====
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types, command codes, register indexes and lookup tables for the
// scrambled bank mapper front end.
// ----------------------------------------------------------------------------
`default_nettype none

package sbm_pkg;

   // Request commands
   typedef enum logic [2:0] {
      CMD_REG_WRITE  = 3'd0,
      CMD_PROT_READ  = 3'd1,
      CMD_CTRL_WRITE = 3'd2,
      CMD_PRG_XLATE  = 3'd3,
      CMD_CHR_XLATE  = 3'd4
   } command_type;

   // Expansion register indexes (3..6 exist on the board but feed nothing)
   localparam logic [2:0] REG_MODE     = 3'd0;
   localparam logic [2:0] REG_OUTER    = 3'd1;
   localparam logic [2:0] REG_PROT_SEL = 3'd2;
   localparam logic [2:0] REG_SCR_SEL  = 3'd7;

   // Reset values
   localparam logic [7:0] MODE_RESET     = 8'h00;
   localparam logic [7:0] OUTER_RESET    = 8'hFF;
   localparam logic [7:0] PROT_SEL_RESET = 8'h07;
   localparam logic [7:0] SCR_SEL_RESET  = 8'h04;

   // Mode register bits
   localparam int MODE_FIXED_BIT = 7;
   localparam int MODE_SMALL_BIT = 6;
   localparam int MODE_KEEP_BIT  = 5;

   localparam logic [7:0]  PRG_MASK_SMALL = 8'h0F;
   localparam logic [7:0]  PRG_MASK_LARGE = 8'h1F;
   localparam logic [10:0] CHR_MASK_SMALL = 11'h07F;
   localparam logic [10:0] CHR_MASK_LARGE = 11'h0FF;

   localparam logic [15:0] PORT_DECODE_MASK = 16'hE001;
   localparam logic [15:0] PORT_BANK_SELECT = 16'h8000;

   localparam logic [3:0] PROT_TAB [8][8] = '{
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd3,  4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd3, 4'd4, 4'd0,  4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd1, 4'd0, 4'd4, 4'd5,  4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd4, 4'd15, 4'd0}
   };

   localparam logic [2:0] DATA_PERM [8][8] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
      '{3'd0, 3'd2, 3'd6, 3'd1, 3'd7, 3'd3, 3'd4, 3'd5},
      '{3'd0, 3'd5, 3'd4, 3'd1, 3'd7, 3'd2, 3'd6, 3'd3},
      '{3'd0, 3'd6, 3'd3, 3'd7, 3'd5, 3'd2, 3'd4, 3'd1},
      '{3'd0, 3'd2, 3'd5, 3'd3, 3'd6, 3'd1, 3'd7, 3'd4},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7}
   };

   localparam logic [15:0] PORT_PERM [8][8] = '{
      '{16'h8000, 16'h8001, 16'hA000, 16'hA001, 16'hC000, 16'hC001, 16'hE000, 16'hE001},
      '{16'hA001, 16'hA000, 16'h8000, 16'hC000, 16'h8001, 16'hC001, 16'hE000, 16'hE001},
      '{16'h8000, 16'h8001, 16'hA000, 16'hA001, 16'hC000, 16'hC001, 16'hE000, 16'hE001},
      '{16'hC001, 16'h8000, 16'h8001, 16'hA000, 16'hA001, 16'hE001, 16'hE000, 16'hC000},
      '{16'hA001, 16'h8001, 16'h8000, 16'hC000, 16'hA000, 16'hC001, 16'hE000, 16'hE001},
      '{16'h8000, 16'h8001, 16'hA000, 16'hA001, 16'hC000, 16'hC001, 16'hE000, 16'hE001},
      '{16'h8000, 16'h8001, 16'hA000, 16'hA001, 16'hC000, 16'hC001, 16'hE000, 16'hE001},
      '{16'h8000, 16'h8001, 16'hA000, 16'hA001, 16'hC000, 16'hC001, 16'hE000, 16'hE001}
   };

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] address;
      logic [7:0]  data;
      logic [7:0]  open_bus;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        forward_valid;
      logic [15:0] forward_address;
      logic [7:0]  forward_data;
      logic [7:0]  prg_bank_out;
      logic [10:0] chr_bank_out;
   } rsp_payload_type;

   // Register file contents seen by the datapath
   typedef struct packed {
      logic [7:0] mode;
      logic [7:0] outer;
      logic [7:0] prot_sel;
      logic [7:0] scr_sel;
      logic       large_board_variant;
   } ext_regs_type;

   // Register write strobe from the pipeline
   typedef struct packed {
      logic       write;
      logic [2:0] index;
      logic [7:0] value;
   } reg_write_type;

endpackage

`default_nettype wire

// ===== hdl/sbm_if.sv =====
// ----------------------------------------------------------------------------
// sbm_if
// Valid/ready channels for requests and responses of the mapper front end.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [15:0] address;
   logic [7:0]  data;
   logic [7:0]  open_bus;

   modport source (output valid, command, address, data, open_bus, input ready);
   modport sink   (input valid, command, address, data, open_bus, output ready);
endinterface

interface sbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        forward_valid;
   logic [15:0] forward_address;
   logic [7:0]  forward_data;
   logic [7:0]  prg_bank_out;
   logic [10:0] chr_bank_out;

   modport source (output valid, read_data, forward_valid, forward_address,
                   forward_data, prg_bank_out, chr_bank_out, input ready);
   modport sink   (input valid, read_data, forward_valid, forward_address,
                   forward_data, prg_bank_out, chr_bank_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/sbm_regs.sv =====
// ----------------------------------------------------------------------------
// sbm_regs
// Expansion registers and the board variant control bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_regs (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sbm_pkg::reg_write_type wr,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_write_data,
   output      sbm_pkg::ext_regs_type regs
);

   sbm_pkg::ext_regs_type regs_ff;
   sbm_pkg::ext_regs_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_write_enable) begin
         regs_in.large_board_variant = csr_write_data;
      end
      if (wr.write) begin
         unique case (wr.index)
            sbm_pkg::REG_MODE:     regs_in.mode     = wr.value;
            sbm_pkg::REG_OUTER:    regs_in.outer    = wr.value;
            sbm_pkg::REG_PROT_SEL: regs_in.prot_sel = wr.value;
            sbm_pkg::REG_SCR_SEL:  regs_in.scr_sel  = wr.value;
            default: ; // indexes 3..6 hold nothing that is ever read
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.mode                <= sbm_pkg::MODE_RESET;
         regs_ff.outer               <= sbm_pkg::OUTER_RESET;
         regs_ff.prot_sel            <= sbm_pkg::PROT_SEL_RESET;
         regs_ff.scr_sel             <= sbm_pkg::SCR_SEL_RESET;
         regs_ff.large_board_variant <= 1'b0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

`default_nettype wire

// ===== hdl/sbm_core.sv =====
// ----------------------------------------------------------------------------
// sbm_core
// Combinational command decode: protection read, port scramble, PRG/CHR
// bank translation.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_core (
   input  wire sbm_pkg::req_payload_type req,
   input  wire sbm_pkg::ext_regs_type    regs,
   output      sbm_pkg::rsp_payload_type rsp
);

   logic [3:0]  prot_nibble;
   logic [2:0]  port_idx;
   logic [15:0] fwd_addr;
   logic        bank_sel_port;
   logic [7:0]  fwd_data;
   logic [7:0]  prg_mask;
   logic [7:0]  prg_base;
   logic [7:0]  prg_keep;
   logic [7:0]  prg_fixed;
   logic [7:0]  prg_inner;
   logic [7:0]  prg_bank;
   logic [10:0] chr_mask;
   logic [2:0]  chr_hi;
   logic [10:0] chr_base;
   logic [10:0] chr_bank;

   always_comb begin
      prot_nibble = sbm_pkg::PROT_TAB[regs.prot_sel[2:0]][req.address[2:0]];

      // controller window: A14..A13 and A0 pick the port
      port_idx      = {req.address[14:13], req.address[0]};
      fwd_addr      = sbm_pkg::PORT_PERM[regs.scr_sel[2:0]][port_idx];
      bank_sel_port = (fwd_addr & sbm_pkg::PORT_DECODE_MASK) == sbm_pkg::PORT_BANK_SELECT;
      fwd_data      = bank_sel_port
                    ? {req.data[7:6], 3'b000,
                       sbm_pkg::DATA_PERM[regs.scr_sel[2:0]][req.data[2:0]]}
                    : req.data;

      // PRG: outer bits rearranged, fixed-bank mode overrides the inner bank
      prg_mask  = regs.mode[sbm_pkg::MODE_SMALL_BIT] ? sbm_pkg::PRG_MASK_SMALL
                                                     : sbm_pkg::PRG_MASK_LARGE;
      prg_base  = {regs.outer[3], regs.outer[1:0], regs.outer[4], 4'b0000};
      prg_keep  = {6'b000000, regs.mode[sbm_pkg::MODE_KEEP_BIT], 1'b1};
      prg_fixed = ({3'b000, regs.mode[3:0], 1'b0} & ~prg_keep)
                | ({6'b000000, req.address[14:13]} & prg_keep);
      prg_inner = regs.mode[sbm_pkg::MODE_FIXED_BIT] ? prg_fixed : req.data;
      prg_bank  = (prg_base & ~prg_mask) | (prg_inner & prg_mask);

      // CHR: large board shifts the outer bank one place further
      chr_mask = regs.mode[sbm_pkg::MODE_SMALL_BIT] ? sbm_pkg::CHR_MASK_SMALL
                                                    : sbm_pkg::CHR_MASK_LARGE;
      chr_hi   = regs.large_board_variant ? regs.outer[3:1] : regs.outer[4:2];
      chr_base = {chr_hi, regs.outer[5], 7'b0000000};
      chr_bank = (chr_base & ~chr_mask) | ({3'b000, req.data} & chr_mask);

      rsp = '0;
      unique case (req.command)
         sbm_pkg::CMD_PROT_READ: begin
            rsp.read_data = {req.open_bus[7:4], prot_nibble};
         end
         sbm_pkg::CMD_CTRL_WRITE: begin
            rsp.forward_valid   = 1'b1;
            rsp.forward_address = fwd_addr;
            rsp.forward_data    = fwd_data;
         end
         sbm_pkg::CMD_PRG_XLATE: begin
            rsp.prg_bank_out = prg_bank;
         end
         sbm_pkg::CMD_CHR_XLATE: begin
            rsp.chr_bank_out = chr_bank;
         end
         default: ; // register writes and unused codes answer with zeros
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/scrambled_bank_mapper_front.sv =====
// ----------------------------------------------------------------------------
// scrambled_bank_mapper_front
// Mapper front end: expansion registers, protection read, controller write
// scramble and outer bank translation, one request per cycle while the response side accepts.
// ----------------------------------------------------------------------------
// Every request returns exactly one response. A request enters an input
// register, is decoded against the expansion registers in a single
// combinational pass and lands in the response register, so a new
// request is taken every cycle while the response side is not stalled.
// A register write (command 0) takes effect for the request right behind it.
// csr_write_data selects the large board CHR outer shift; write it only
// while no request is in flight.
`default_nettype none

module scrambled_bank_mapper_front (
   input  wire logic   clock,
   input  wire logic   reset,
   sbm_req_if.sink     req_if,
   sbm_rsp_if.source   rsp_if,
   input  wire logic   csr_write_enable,
   input  wire logic   csr_write_data
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   sbm_pkg::req_payload_type in_data_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   sbm_pkg::rsp_payload_type out_data_ff;
   sbm_pkg::rsp_payload_type core_rsp;
   sbm_pkg::ext_regs_type    regs;
   sbm_pkg::reg_write_type   reg_wr;
   logic                     req_fire;
   logic                     rsp_fire;
   logic                     advance;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = out_valid_ff && rsp_if.ready;

   assign req_if.ready = !in_valid_ff || advance;

   assign reg_wr.write = advance && (in_data_ff.command == sbm_pkg::CMD_REG_WRITE);
   assign reg_wr.index = in_data_ff.address[2:0];
   assign reg_wr.value = in_data_ff.data;

   sbm_regs u_regs (
      .clock            (clock),
      .reset            (reset),
      .wr               (reg_wr),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .regs             (regs)
   );

   sbm_core u_core (
      .req  (in_data_ff),
      .regs (regs),
      .rsp  (core_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff.command  <= req_if.command;
         in_data_ff.address  <= req_if.address;
         in_data_ff.data     <= req_if.data;
         in_data_ff.open_bus <= req_if.open_bus;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.read_data       = out_data_ff.read_data;
   assign rsp_if.forward_valid   = out_data_ff.forward_valid;
   assign rsp_if.forward_address = out_data_ff.forward_address;
   assign rsp_if.forward_data    = out_data_ff.forward_data;
   assign rsp_if.prg_bank_out    = out_data_ff.prg_bank_out;
   assign rsp_if.chr_bank_out    = out_data_ff.chr_bank_out;

endmodule

`default_nettype wire

// ===== hdl/sbm_checker.sv =====
// ----------------------------------------------------------------------------
// sbm_checker
// Port-level checks on the mapper front end response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_read_data,
   input wire logic        rsp_forward_valid,
   input wire logic [15:0] rsp_forward_address,
   input wire logic [7:0]  rsp_forward_data,
   input wire logic [7:0]  rsp_prg_bank_out,
   input wire logic [10:0] rsp_chr_bank_out
);

   // a stalled response stays valid and keeps its bank and forward address fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prg_bank_out)
         && $stable(rsp_chr_bank_out) && $stable(rsp_forward_address))
      else $error("response changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_fwd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_forward_valid |->
         rsp_forward_address == 16'h0000 && rsp_forward_data == 8'h00)
      else $error("forward fields set without a forwarded write");

   // only one command's result fields can be nonzero
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_read_data != 8'h00, rsp_forward_valid,
         rsp_prg_bank_out != 8'h00, rsp_chr_bank_out != 11'h000}) <= 1)
      else $error("response mixes results of different commands");

endmodule

bind scrambled_bank_mapper_front sbm_checker u_sbm_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_read_data       (rsp_if.read_data),
   .rsp_forward_valid   (rsp_if.forward_valid),
   .rsp_forward_address (rsp_if.forward_address),
   .rsp_forward_data    (rsp_if.forward_data),
   .rsp_prg_bank_out    (rsp_if.prg_bank_out),
   .rsp_chr_bank_out    (rsp_if.chr_bank_out)
);

`default_nettype wire
